// ===== rtl/gtp_pkg.sv =====
`default_nettype none
package gtp_pkg;

    localparam int ACC_W = 56;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

    localparam logic [17:0] TURN_DEADBAND = 18'd4;
    localparam logic [17:0] TURN_ILIMIT   = 18'd16384;
    localparam logic [21:0] LAT_DEADBAND  = 22'd25;
    localparam logic [21:0] LAT_ILIMIT    = 22'd512;
    localparam logic [21:0] DONE_DIST     = 22'd256;

    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Y = 3'd1;
    localparam logic [2:0] REG_TURN_KP  = 3'd2;
    localparam logic [2:0] REG_TURN_KI  = 3'd3;
    localparam logic [2:0] REG_TURN_KD  = 3'd4;
    localparam logic [2:0] REG_LAT_KP   = 3'd5;
    localparam logic [2:0] REG_LAT_KI   = 3'd6;
    localparam logic [2:0] REG_LAT_KD   = 3'd7;

    localparam logic [15:0] TURN_KP_RST = 16'd12800;
    localparam logic [15:0] TURN_KI_RST = 16'd461;
    localparam logic [15:0] TURN_KD_RST = 16'd7680;
    localparam logic [15:0] LAT_KP_RST  = 16'd269;
    localparam logic [15:0] LAT_KI_RST  = 16'd6400;
    localparam logic [15:0] LAT_KD_RST  = 16'd102;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_ERR,
        ST_UPD,
        ST_MAC,
        ST_SUM,
        ST_OUT
    } gtp_state_t;

    // round(atan(2^-i) * 8192)
    function automatic logic [12:0] atan_lut(input logic [3:0] idx);
        logic [12:0] v;
        begin
            case (idx)
                4'd0:    v = 13'd6434;
                4'd1:    v = 13'd3798;
                4'd2:    v = 13'd2007;
                4'd3:    v = 13'd1019;
                4'd4:    v = 13'd511;
                4'd5:    v = 13'd256;
                4'd6:    v = 13'd128;
                4'd7:    v = 13'd64;
                4'd8:    v = 13'd32;
                4'd9:    v = 13'd16;
                4'd10:   v = 13'd8;
                4'd11:   v = 13'd4;
                4'd12:   v = 13'd2;
                4'd13:   v = 13'd1;
                default: v = 13'd0;
            endcase
            atan_lut = v;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic [32:0] s);
        logic [31:0] v;
        begin
            if (s[32] != s[31])
                v = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                v = s[31:0];
            sat32 = v;
        end
    endfunction

    // truncate toward zero by 2^21, clamp to +-127
    function automatic logic [7:0] to_power(input logic signed [ACC_W-1:0] v);
        logic signed [34:0] q;
        logic [7:0] p;
        begin
            q = v[ACC_W-1:21];
            if (v[ACC_W-1] && (v[20:0] != 21'd0))
                q = q + 35'sd1;
            if (q > 35'sd127)
                p = 8'd127;
            else if (q < -35'sd127)
                p = 8'h81;
            else
                p = q[7:0];
            to_power = p;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gtp_sqrt.sv =====
`default_nettype none
module gtp_sqrt
    import gtp_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [20:0] dx,
    input  wire signed [20:0] dy,
    output logic              done,
    output logic [21:0]       root
);

    localparam logic [4:0] SQ_LAST = 5'd23;

    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [39:0] sq_reg;
    logic [41:0] n_reg;
    logic [41:0] r_reg;
    logic [41:0] bit_reg;

    logic [20:0] ax;
    logic [20:0] ay;
    logic [19:0] mul_a;
    logic [39:0] prod;
    logic [41:0] trial;

    assign ax    = dx[20] ? 21'(-dx) : dx;
    assign ay    = dy[20] ? 21'(-dy) : dy;
    assign mul_a = (cnt_reg == 5'd0) ? ax[19:0] : ay[19:0];
    assign prod  = 40'(mul_a) * 40'(mul_a);
    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == SQ_LAST)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // squares dx and dy in turn and sums them, then one radix-4 digit per cycle
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            case (cnt_reg)
                5'd0:
                begin
                    sq_reg <= prod;
                end
                5'd1:
                begin
                    n_reg  <= {2'b00, sq_reg};
                    sq_reg <= prod;
                end
                5'd2:
                begin
                    n_reg   <= n_reg + {2'b00, sq_reg};
                    r_reg   <= 42'd0;
                    bit_reg <= {2'b01, 40'd0};
                end
                default:
                begin
                    if (n_reg >= trial)
                    begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign root = r_reg[21:0];

endmodule
`default_nettype wire

// ===== rtl/gtp_cordic.sv =====
`default_nettype none
module gtp_cordic
    import gtp_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [20:0] dx,
    input  wire signed [20:0] dy,
    output logic              done,
    output logic signed [17:0] angle
);

    localparam logic [3:0] CORDIC_LAST = 4'd13;

    logic               run_reg;
    logic               done_reg;
    logic [3:0]         i_reg;
    logic               hold_reg;
    logic signed [39:0] x_reg;
    logic signed [39:0] y_reg;
    logic signed [17:0] z_reg;

    logic signed [39:0] x0;
    logic signed [39:0] y0;
    logic signed [39:0] sx;
    logic signed [39:0] sy;
    logic signed [17:0] step;
    logic               ypos;

    assign x0   = {{3{dy[20]}}, dy, 16'd0};
    assign y0   = {{3{dx[20]}}, dx, 16'd0};
    assign sx   = x_reg >>> i_reg;
    assign sy   = y_reg >>> i_reg;
    assign step = {5'd0, atan_lut(i_reg)};
    assign ypos = !y_reg[39] && (y_reg != 40'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 4'd0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            i_reg    <= 4'd0;
        end
        else if (run_reg)
        begin
            i_reg <= i_reg + 4'd1;
            if (i_reg == CORDIC_LAST)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // on-axis cases skip the rotation
            if (dx == 21'sd0)
            begin
                hold_reg <= 1'b1;
                z_reg    <= dy[20] ? PI_Q13 : 18'sd0;
            end
            else if (dy == 21'sd0)
            begin
                hold_reg <= 1'b1;
                z_reg    <= dx[20] ? -HALF_PI_Q13 : HALF_PI_Q13;
            end
            else
            begin
                hold_reg <= 1'b0;
                if (dy[20])
                begin
                    x_reg <= -x0;
                    y_reg <= -y0;
                    z_reg <= dx[20] ? -PI_Q13 : PI_Q13;
                end
                else
                begin
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= 18'sd0;
                end
            end
        end
        else if (run_reg && !hold_reg)
        begin
            if (ypos)
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + step;
            end
            else
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - step;
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule
`default_nettype wire

// ===== rtl/gtp_mac.sv =====
`default_nettype none
module gtp_mac
    import gtp_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire signed [ACC_W-1:0]  op0,
    input  wire signed [ACC_W-1:0]  op1,
    input  wire signed [ACC_W-1:0]  op2,
    input  wire [15:0]              g0,
    input  wire [15:0]              g1,
    input  wire [15:0]              g2,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);

    localparam logic [1:0] MAC_LAST_P = 2'd2;
    localparam logic [3:0] MAC_LAST_B = 4'd15;

    logic                    run_reg;
    logic                    done_reg;
    logic [1:0]              p_reg;
    logic [3:0]              b_reg;
    logic signed [ACC_W-1:0] sh_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [15:0]             gsel;
    logic signed [ACC_W-1:0] op_next;

    always_comb
    begin
        case (p_reg)
            2'd0:    gsel = g0;
            2'd1:    gsel = g1;
            default: gsel = g2;
        endcase
        op_next = (p_reg == 2'd0) ? op1 : op2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            p_reg    <= 2'd0;
            b_reg    <= 4'd0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            p_reg    <= 2'd0;
            b_reg    <= 4'd0;
        end
        else if (run_reg)
        begin
            b_reg <= b_reg + 4'd1;
            if (b_reg == MAC_LAST_B)
            begin
                if (p_reg == MAC_LAST_P)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    p_reg <= p_reg + 2'd1;
                end
            end
        end
    end

    // one gain bit per cycle, three products in turn
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            sh_reg  <= op0;
        end
        else if (run_reg)
        begin
            if (gsel[b_reg])
                acc_reg <= acc_reg + sh_reg;
            if (b_reg == MAC_LAST_B)
                sh_reg <= op_next;
            else
                sh_reg <= sh_reg <<< 1;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/go_to_point_dual_pid_unit.sv =====
// One transaction at a time: a new input is taken only in the idle state, after the previous
// one has passed the root unit (two squares, then one radix-4 digit per cycle), the angle unit
// and the two bit-serial MACs; when within the done distance the MACs are skipped.
// The next input is taken while a result still waits in the output register.
// Reset (rst_n low, asynchronous): gains and targets to defaults, loop state cleared.
`default_nettype none
module go_to_point_dual_pid_unit
    import gtp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [55:0]  s_axis_tdata,   // pos_x, pos_y, heading
    input  wire [0:0]   s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // left_power, right_power
    output logic [0:0]  m_axis_tuser,   // done_res
    input  wire         cfg_we,
    input  wire [2:0]   cfg_addr,
    input  wire [19:0]  cfg_data
);

    gtp_state_t state_reg, state_next;

    logic [19:0] tx_reg, ty_reg;
    logic [15:0] tkp_reg, tki_reg, tkd_reg, lkp_reg, lki_reg, lkd_reg;

    logic [31:0] t_int_reg;
    logic [17:0] t_last_reg;
    logic [31:0] l_int_reg;
    logic [21:0] l_last_reg;

    logic               go_reg;
    logic               mac_go_reg;
    logic signed [20:0] dx_reg, dy_reg;
    logic [15:0]        hd_reg;
    logic signed [17:0] e_reg;
    logic [21:0]        d_reg;
    logic               fin_reg;

    logic [17:0] t_op0_reg;
    logic [31:0] t_op1_reg;
    logic [18:0] t_op2_reg;
    logic [21:0] l_op0_reg;
    logic [31:0] l_op1_reg;
    logic [22:0] l_op2_reg;

    logic signed [ACC_W-1:0] vl_reg, vr_reg;
    logic                    ov_reg;
    logic [7:0]              out_l_reg, out_r_reg;
    logic                    out_d_reg;

    logic s_acc;
    logic out_load;

    logic               sq_done, cor_done, mt_done, ml_done;
    logic [21:0]        root;
    logic signed [17:0] cor_z;
    logic signed [ACC_W-1:0] turn_acc, lat_acc, lat32;

    logic signed [17:0] e_calc;
    logic [17:0] ae;
    logic        t_act;
    logic [31:0] t_inew;
    logic [31:0] t_iuse;
    logic [18:0] t_der;
    logic        l_act;
    logic [31:0] l_inew;
    logic [31:0] l_iuse;
    logic [22:0] l_der;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg  <= 20'd0;
            ty_reg  <= 20'd0;
            tkp_reg <= TURN_KP_RST;
            tki_reg <= TURN_KI_RST;
            tkd_reg <= TURN_KD_RST;
            lkp_reg <= LAT_KP_RST;
            lki_reg <= LAT_KI_RST;
            lkd_reg <= LAT_KD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET_X: tx_reg  <= cfg_data;
                REG_TARGET_Y: ty_reg  <= cfg_data;
                REG_TURN_KP:  tkp_reg <= cfg_data[15:0];
                REG_TURN_KI:  tki_reg <= cfg_data[15:0];
                REG_TURN_KD:  tkd_reg <= cfg_data[15:0];
                REG_LAT_KP:   lkp_reg <= cfg_data[15:0];
                REG_LAT_KI:   lki_reg <= cfg_data[15:0];
                REG_LAT_KD:   lkd_reg <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // ---------------- FSM ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = ST_SOLVE;
            end
            ST_SOLVE:
            begin
                if (!go_reg && sq_done && cor_done)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                state_next = (root <= DONE_DIST) ? ST_OUT : ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (!mac_go_reg && mt_done && ml_done)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg     <= 1'b0;
            mac_go_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            go_reg     <= s_acc;
            mac_go_reg <= (state_reg == ST_UPD);
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    // ---------------- input and error stage ----------------
    assign e_calc = 18'sd0 - cor_z - {{2{hd_reg[15]}}, hd_reg};

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            dx_reg <= {tx_reg[19], tx_reg} - {s_axis_tdata[19], s_axis_tdata[19:0]};
            dy_reg <= {ty_reg[19], ty_reg} - {s_axis_tdata[39], s_axis_tdata[39:20]};
            hd_reg <= s_axis_tdata[55:40];
        end
        if (state_reg == ST_ERR)
        begin
            e_reg   <= e_calc;
            d_reg   <= root;
            fin_reg <= (root <= DONE_DIST);
        end
    end

    // ---------------- loop update ----------------
    always_comb
    begin
        ae     = e_reg[17] ? 18'(-e_reg) : e_reg;
        t_act  = ae > TURN_DEADBAND;
        t_inew = (ae < TURN_ILIMIT) ?
                 sat32({t_int_reg[31], t_int_reg} + {{15{e_reg[17]}}, e_reg}) : 32'd0;
        t_iuse = (tki_reg != 16'd0) ? t_inew : t_int_reg;
        t_der  = {e_reg[17], e_reg} - {t_last_reg[17], t_last_reg};

        l_act  = d_reg > LAT_DEADBAND;
        l_inew = (d_reg < LAT_ILIMIT) ?
                 sat32({l_int_reg[31], l_int_reg} + {11'd0, d_reg}) : 32'd0;
        l_iuse = (lki_reg != 16'd0) ? l_inew : l_int_reg;
        l_der  = {1'b0, d_reg} - {1'b0, l_last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_int_reg  <= 32'd0;
            t_last_reg <= 18'd0;
            l_int_reg  <= 32'd0;
            l_last_reg <= 22'd0;
        end
        else if (s_acc && s_axis_tuser[0])
        begin
            t_int_reg  <= 32'd0;
            t_last_reg <= 18'd0;
            l_int_reg  <= 32'd0;
            l_last_reg <= 22'd0;
        end
        else if (state_reg == ST_UPD)
        begin
            t_int_reg  <= t_act ? t_iuse : 32'd0;
            t_last_reg <= t_act ? e_reg : 18'd0;
            l_int_reg  <= l_act ? l_iuse : 32'd0;
            l_last_reg <= l_act ? d_reg : 22'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD)
        begin
            t_op0_reg <= t_act ? e_reg : 18'd0;
            t_op1_reg <= t_act ? t_iuse : 32'd0;
            t_op2_reg <= t_act ? t_der : 19'd0;
            l_op0_reg <= l_act ? d_reg : 22'd0;
            l_op1_reg <= l_act ? l_iuse : 32'd0;
            l_op2_reg <= l_act ? l_der : 23'd0;
        end
        if (state_reg == ST_SUM)
        begin
            vl_reg <= lat32 - turn_acc;
            vr_reg <= lat32 + turn_acc;
        end
        if (out_load)
        begin
            out_l_reg <= fin_reg ? 8'd0 : to_power(vl_reg);
            out_r_reg <= fin_reg ? 8'd0 : to_power(vr_reg);
            out_d_reg <= fin_reg;
        end
    end

    assign lat32 = {lat_acc[ACC_W-6:0], 5'd0};

    // ---------------- units ----------------
    gtp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .done  (sq_done),
        .root  (root)
    );

    gtp_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .done  (cor_done),
        .angle (cor_z)
    );

    gtp_mac u_mac_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_go_reg),
        .op0   ({{38{t_op0_reg[17]}}, t_op0_reg}),
        .op1   ({{24{t_op1_reg[31]}}, t_op1_reg}),
        .op2   ({{37{t_op2_reg[18]}}, t_op2_reg}),
        .g0    (tkp_reg),
        .g1    (tki_reg),
        .g2    (tkd_reg),
        .done  (mt_done),
        .acc   (turn_acc)
    );

    gtp_mac u_mac_lat (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_go_reg),
        .op0   ({34'd0, l_op0_reg}),
        .op1   ({{24{l_op1_reg[31]}}, l_op1_reg}),
        .op2   ({{33{l_op2_reg[22]}}, l_op2_reg}),
        .g0    (lkp_reg),
        .g1    (lki_reg),
        .g2    (lkd_reg),
        .done  (ml_done),
        .acc   (lat_acc)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};
    assign m_axis_tuser  = out_d_reg;

    // ---------------- assertions ----------------
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("done transaction with nonzero power");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[15:8] != 8'h80))
        else $error("power outside saturation range");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tuser[0]) |=> (t_int_reg == 32'd0 && l_last_reg == 22'd0))
        else $error("start_req did not clear loop state");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");

endmodule
`default_nettype wire

// ===== sim/go_to_point_dual_pid_unit_test.sv =====
`timescale 1ns / 1ps
module go_to_point_dual_pid_unit_test
    import gtp_pkg::*;
();

    typedef struct packed {
        logic signed [7:0] left_pw;
        logic signed [7:0] right_pw;
        logic              done;
    } drive_cmd_t;

    typedef struct {
        logic              start;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [15:0] hd;
        logic              has_exp;
        drive_cmd_t        exp_cmd;
    } pose_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [19:0] cfg_data;

    go_to_point_dual_pid_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // model copy of registers and loop state
    longint gain_tgt_x, gain_tgt_y;
    longint g_tkp, g_tki, g_tkd, g_lkp, g_lki, g_lkd;
    longint t_int, t_last, l_int, l_last;

    drive_cmd_t pending_cmds[$];
    int   err_count;
    int   src_idle_pct;
    int   snk_stall_pct;

    localparam longint ATAN_TBL[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                        32, 16, 8, 4, 2, 1};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint bearing_q13(longint ya, longint xa);
        longint x, y, z, base, nx, ny;
        z = 0;
        base = 0;
        if (ya == 0)
            return (xa < 0) ? 25736 : 0;
        if (xa == 0)
            return (ya > 0) ? 12868 : -12868;
        x = xa * 65536;
        y = ya * 65536;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = (ya >= 0) ? 25736 : -25736;
        end
        for (int i = 0; i < 14; i++)
        begin
            if (y > 0)
            begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z += ATAN_TBL[i];
            end
            else
            begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z -= ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        return base + z;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [7:0] motor_level(longint v);
        longint q;
        q = v / 2097152;
        if (q > 127)
            q = 127;
        if (q < -127)
            q = -127;
        return q[7:0];
    endfunction

    function automatic drive_cmd_t steer_step(logic start, longint px, longint py,
                                              longint hd);
        drive_cmd_t c;
        longint dx, dy, d, e, ae, turn, lat, der;
        turn = 0;
        lat = 0;
        if (start)
        begin
            t_int = 0; t_last = 0; l_int = 0; l_last = 0;
        end
        dx = gain_tgt_x - px;
        dy = gain_tgt_y - py;
        d = root_floor(dx * dx + dy * dy);
        if (d <= 256)
        begin
            c.left_pw = 0;
            c.right_pw = 0;
            c.done = 1'b1;
            return c;
        end
        e = -bearing_q13(dx, dy) - hd;
        ae = (e < 0) ? -e : e;
        if (ae > 4)
        begin
            if (g_tki != 0)
                t_int = (ae < 16384) ? clamp32(t_int + e) : 0;
            der = e - t_last;
            t_last = e;
            turn = g_tkp * e + g_tki * t_int + g_tkd * der;
        end
        else
        begin
            t_int = 0;
            t_last = 0;
        end
        if (d > 25)
        begin
            if (g_lki != 0)
                l_int = (d < 512) ? clamp32(l_int + d) : 0;
            der = d - l_last;
            l_last = d;
            lat = g_lkp * d + g_lki * l_int + g_lkd * der;
        end
        else
        begin
            l_int = 0;
            l_last = 0;
        end
        c.left_pw = motor_level(lat * 32 - turn);
        c.right_pw = motor_level(lat * 32 + turn);
        c.done = 1'b0;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET_X: gain_tgt_x = $signed(val);
            REG_TARGET_Y: gain_tgt_y = $signed(val);
            REG_TURN_KP:  g_tkp = val[15:0];
            REG_TURN_KI:  g_tki = val[15:0];
            REG_TURN_KD:  g_tkd = val[15:0];
            REG_LAT_KP:   g_lkp = val[15:0];
            REG_LAT_KI:   g_lki = val[15:0];
            REG_LAT_KD:   g_lkd = val[15:0];
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_pose(pose_row_t row);
        drive_cmd_t c;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.hd, row.py, row.px};
        s_axis_tuser <= row.start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        c = steer_step(row.start, row.px, row.py, row.hd);
        if (row.has_exp && c != row.exp_cmd)
            report_mismatch("table row", c, row.exp_cmd);
        pending_cmds.push_back(row.has_exp ? row.exp_cmd : c);
        @(negedge clk);
    endtask

    task automatic drain;
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (100) @(negedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        drive_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected transaction", m_axis_tdata, 0);
            else
            begin
                want = pending_cmds.pop_front();
                if ($signed(m_axis_tdata[7:0]) != want.left_pw)
                    report_mismatch("left_power", $signed(m_axis_tdata[7:0]), want.left_pw);
                if ($signed(m_axis_tdata[15:8]) != want.right_pw)
                    report_mismatch("right_power", $signed(m_axis_tdata[15:8]),
                                    want.right_pw);
                if (m_axis_tuser[0] != want.done)
                    report_mismatch("done_res", m_axis_tuser[0], want.done);
            end
        end
    end

    function automatic logic signed [19:0] near_coord(longint base);
        longint v;
        case ($urandom_range(3))
            0: v = base + $signed(20'($urandom_range(600))) - 300;
            1: v = base + $signed(20'($urandom_range(8000))) - 4000;
            2: v = $signed(20'($urandom));
            default: v = base + $signed(20'($urandom_range(30))) - 15;
        endcase
        return v[19:0];
    endfunction

    task automatic random_run(int count);
        pose_row_t row;
        longint cx, cy;
        cx = $signed(20'($urandom));
        cy = $signed(20'($urandom));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(15) == 0)
            begin
                cx = $signed(20'($urandom));
                cy = $signed(20'($urandom));
            end
            row.start = ($urandom_range(9) == 0);
            if ($urandom_range(4) == 0)
            begin
                row.px = 20'($urandom);
                row.py = 20'($urandom);
            end
            else
            begin
                cx = (cx * 7 + gain_tgt_x) / 8 + $signed(9'($urandom)) ;
                cy = (cy * 7 + gain_tgt_y) / 8 + $signed(9'($urandom));
                row.px = (i % 5 == 0) ? near_coord(gain_tgt_x) : cx[19:0];
                row.py = (i % 5 == 0) ? near_coord(gain_tgt_y) : cy[19:0];
            end
            row.hd = ($urandom_range(7) == 0) ? 16'($urandom)
                     : 16'(int'($urandom_range(51472)) - 25736);
            row.has_exp = 1'b0;
            send_pose(row);
        end
    endtask

    pose_row_t dir_rows[$];

    function automatic pose_row_t mk(logic st, longint x, longint y, longint h,
                                     logic he, drive_cmd_t ex);
        pose_row_t r;
        r.start = st; r.px = x; r.py = y; r.hd = h; r.has_exp = he; r.exp_cmd = ex;
        return r;
    endfunction

    initial
    begin
        drive_cmd_t at_goal, none;
        at_goal = '{8'sd0, 8'sd0, 1'b1};
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_TARGET_X;
        cfg_data = '0;
        err_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        gain_tgt_x = 0; gain_tgt_y = 0;
        g_tkp = TURN_KP_RST; g_tki = TURN_KI_RST; g_tkd = TURN_KD_RST;
        g_lkp = LAT_KP_RST; g_lki = LAT_KI_RST; g_lkd = LAT_KD_RST;
        t_int = 0; t_last = 0; l_int = 0; l_last = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows.push_back(mk(1, 0, 0, 0, 1, at_goal));
        dir_rows.push_back(mk(0, 256, 0, 0, 1, at_goal));
        dir_rows.push_back(mk(0, 0, -256, 16'sh7fff, 1, at_goal));
        dir_rows.push_back(mk(0, 257, 0, 0, 0, none));
        dir_rows.push_back(mk(0, -2000, 0, 0, 0, none));
        dir_rows.push_back(mk(0, 0, 2000, 0, 0, none));
        dir_rows.push_back(mk(0, 0, -2000, 0, 0, none));
        dir_rows.push_back(mk(0, 300, 300, -6434, 0, none));
        dir_rows.push_back(mk(0, -300, 300, 6434, 0, none));
        dir_rows.push_back(mk(0, 2000, 0, 25736, 0, none));
        dir_rows.push_back(mk(0, 2000, 0, -25736, 0, none));
        dir_rows.push_back(mk(0, 2000, 0, 16'sh8000, 0, none));
        dir_rows.push_back(mk(0, 2000, 0, 16'sh7fff, 0, none));
        dir_rows.push_back(mk(0, 524287, 524287, 0, 0, none));
        dir_rows.push_back(mk(0, -524288, -524288, 0, 0, none));
        dir_rows.push_back(mk(0, 524287, -524288, 1000, 0, none));
        dir_rows.push_back(mk(1, 400, 10, 0, 0, none));
        dir_rows.push_back(mk(0, 400, 10, 3, 0, none));
        dir_rows.push_back(mk(0, 400, 10, 0, 0, none));
        dir_rows.push_back(mk(1, 600, -20, 100, 0, none));
        foreach (dir_rows[i])
            send_pose(dir_rows[i]);
        drain();

        // zero integral gains: integrals stop accumulating
        write_reg(REG_TURN_KI, 20'd0);
        write_reg(REG_LAT_KI, 20'd0);
        write_reg(REG_TARGET_X, 20'd1000);
        write_reg(REG_TARGET_Y, 20'hFFC00);
        random_run(40);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 73) : 0;
            snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 73) : 0;
            case (ph)
                0:
                begin
                    write_reg(REG_TURN_KP, 20'hFFFF);
                    write_reg(REG_TURN_KI, 20'hFFFF);
                    write_reg(REG_TURN_KD, 20'hFFFF);
                    write_reg(REG_LAT_KP, 20'hFFFF);
                    write_reg(REG_LAT_KI, 20'hFFFF);
                    write_reg(REG_LAT_KD, 20'hFFFF);
                    write_reg(REG_TARGET_X, 20'h7FFFF);
                    write_reg(REG_TARGET_Y, 20'h80000);
                end
                1:
                begin
                    write_reg(REG_TURN_KP, 20'd0);
                    write_reg(REG_TURN_KD, 20'd0);
                    write_reg(REG_LAT_KP, 20'd1);
                    write_reg(REG_LAT_KD, 20'd0);
                    write_reg(REG_TARGET_X, 20'h80000);
                    write_reg(REG_TARGET_Y, 20'h7FFFF);
                end
                default:
                begin
                    write_reg(REG_TURN_KP, 20'($urandom_range(65535)));
                    write_reg(REG_TURN_KI, 20'($urandom_range(2000)));
                    write_reg(REG_TURN_KD, 20'($urandom_range(65535)));
                    write_reg(REG_LAT_KP, 20'($urandom_range(2000)));
                    write_reg(REG_LAT_KI, 20'($urandom_range(65535)));
                    write_reg(REG_LAT_KD, 20'($urandom_range(2000)));
                    write_reg(REG_TARGET_X, 20'($urandom));
                    write_reg(REG_TARGET_Y, 20'($urandom));
                end
            endcase
            random_run(90);
            drain();
        end

        if (pending_cmds.size() == 0 && err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
